// ===== rtl/utf8_text_validator_macros.svh =====
// Assertion macros for the UTF-8 text validator.
`ifndef UTF8_TEXT_VALIDATOR_MACROS_SVH
`define UTF8_TEXT_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS

// Immediate implication: cond must hold on the same edge as trig.
`define UTV_ASSERT_IMP(name, trig, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("utv: assertion failed");

// Next-cycle implication: cond must hold on the edge after trig.
`define UTV_ASSERT_NXT(name, trig, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("utv: assertion failed");

`else

`define UTV_ASSERT_IMP(name, trig, cond)
`define UTV_ASSERT_NXT(name, trig, cond)

`endif

`endif

// ===== rtl/utv_pkg.sv =====
// Shared types and constants of the UTF-8 text validator.
`timescale 1ns / 1ps

package utv_pkg;

  // Byte counter: COUNT_BITS plus one bit so saturation is visible.
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CNT_W      = COUNT_BITS + 1;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned TOTAL_W    = 16;
  localparam int unsigned CP_W       = 21;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd255;

  // Code point bounds for the form checks.
  localparam logic [CP_W-1:0] CP_MIN_2B   = 21'h00080;
  localparam logic [CP_W-1:0] CP_MIN_3B   = 21'h00800;
  localparam logic [CP_W-1:0] CP_MIN_4B   = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h0D800;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h0DFFF;

  localparam logic [7:0] CTL_LIMIT = 8'h20;
  localparam logic [7:0] CTL_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    VERDICT_VALID    = 2'd0,
    VERDICT_TOO_LONG = 2'd1,
    VERDICT_CONTROL  = 2'd2,
    VERDICT_BAD_UTF8 = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       carries_byte;
    logic       string_end;
  } item_t;

  typedef struct packed {
    verdict_e           verdict;
    logic [TOTAL_W-1:0] byte_total;
  } result_t;

endpackage

// ===== rtl/utv_if.sv =====
// Stream and configuration channel interfaces of the UTF-8 text validator.
`timescale 1ns / 1ps

interface utv_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       carries_byte;
  logic       string_end;

  modport source (output valid, output text_byte, output carries_byte,
                  output string_end, input ready);
  modport sink   (input valid, input text_byte, input carries_byte,
                  input string_end, output ready);
endinterface

interface utv_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [15:0] byte_total;

  modport source (output valid, output verdict, output byte_total, input ready);
  modport sink   (input valid, input verdict, input byte_total, output ready);
endinterface

interface utv_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/utf8_text_validator.sv =====
// Top level of the UTF-8 text validator: input register, tracker, result register.
`timescale 1ns / 1ps

//  channel   dir  modport  payload                                  transfer
//  --------  ---  -------  ---------------------------------------  ---------------
//  text_i    in   sink     text_byte[7:0], carries_byte, string_end valid && ready
//  result_o  out  source   verdict[1:0], byte_total[15:0]           valid && ready
//  cfg_i     in   sink     data[15:0] -> length_limit               valid (ready=1)
//
//  One item per cycle sustained unless an end item waits on an untaken verdict;
//  a verdict passes through the input register, then the result register.
//  The per-string state updates as an item leaves the input register.
//  Reset clears all string state, empties both registers, length_limit = 255.
//  A stalled result only blocks an end item; other items keep flowing past it.

module utf8_text_validator
  import utv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  utv_text_if.sink     text_i,
  utv_result_if.source result_o,
  utv_cfg_if.sink      cfg_i
);

`include "utf8_text_validator_macros.svh"

  logic               in_valid_q;
  item_t              item_q;
  logic               out_valid_q;
  result_t            out_q;
  logic [LIMIT_W-1:0] limit_q;

  logic    text_xfer;
  logic    advance;
  logic    load_out;
  result_t res;

  // config channel always ready; the user must write only while idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  // An item leaves the input register unless it is an end item and the
  // result register is still occupied by an untaken verdict.
  assign advance   = in_valid_q && (!item_q.string_end || !out_valid_q || result_o.ready);
  assign load_out  = advance && item_q.string_end;
  assign text_i.ready = !in_valid_q || advance;
  assign text_xfer = text_i.valid && text_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (text_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (text_xfer) begin
      item_q.text_byte    <= text_i.text_byte;
      item_q.carries_byte <= text_i.carries_byte;
      item_q.string_end   <= text_i.string_end;
    end
  end

  utv_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .item_i  (item_q),
    .limit_i (limit_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.verdict    = out_q.verdict;
  assign result_o.byte_total = out_q.byte_total;

  // never overwrite a verdict that has not been taken
  `UTV_ASSERT_IMP(a_no_overwrite, out_valid_q && !result_o.ready, !load_out)
  // back pressure only comes from a held end item
  `UTV_ASSERT_IMP(a_stall_cause, !text_i.ready, in_valid_q && item_q.string_end && out_valid_q)

endmodule

// ===== rtl/utv_tracker.sv =====
// Per-string state: byte count, control flag and UTF-8 decode state.
`timescale 1ns / 1ps

module utv_tracker
  import utv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  item_t              item_i,
  input  logic [LIMIT_W-1:0] limit_i,
  output result_t            res_o
);

`include "utf8_text_validator_macros.svh"

  localparam logic [CNT_W-1:0] CNT_CAP = {1'b1, {COUNT_BITS{1'b0}}};

  logic [1:0]      pend_q, pend_d;
  logic [1:0]      seq_q, seq_d;
  logic [CP_W-1:0] part_q, part_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic            ctl_q, ctl_d;
  logic            mal_q, mal_d;

  // state after this item's byte, before the end-of-string clear
  logic [1:0]       pend_b, seq_b;
  logic [CP_W-1:0]  part_b;
  logic [CNT_W-1:0] cnt_b;
  logic             ctl_b, mal_b, mal_end;

  logic [7:0]       b;
  logic             ctl_byte, cont_ok, range_bad;
  logic [CP_W-1:0]  cp_cat;
  logic [CNT_W+TOTAL_W-1:0] cnt_ext;

  assign b        = item_i.text_byte;
  assign ctl_byte = (b < CTL_LIMIT) || (b == CTL_DEL) || (b[7:5] == 3'b100);
  assign cont_ok  = (b[7:6] == 2'b10);
  assign cp_cat   = {part_q[CP_W-7:0], b[5:0]};
  assign range_bad = ((seq_q == 2'd1) && (cp_cat < CP_MIN_2B))
                  || ((seq_q == 2'd2) && (cp_cat < CP_MIN_3B))
                  || ((seq_q == 2'd3) && (cp_cat < CP_MIN_4B))
                  || (cp_cat > CP_MAX)
                  || ((cp_cat >= CP_SURR_LO) && (cp_cat <= CP_SURR_HI));

  always_comb begin
    pend_b = pend_q;
    seq_b  = seq_q;
    part_b = part_q;
    cnt_b  = cnt_q;
    ctl_b  = ctl_q;
    mal_b  = mal_q;
    if (item_i.carries_byte) begin
      if (cnt_q != CNT_CAP) begin
        cnt_b = cnt_q + CNT_W'(1);
      end
      ctl_b = ctl_q | ctl_byte;
      if (!mal_q) begin
        if (pend_q == 2'd0) begin
          if (!b[7]) begin
            // plain ASCII, nothing to track
          end else if (b[7:5] == 3'b110) begin
            seq_b  = 2'd1;
            pend_b = 2'd1;
            part_b = CP_W'(b[4:0]);
          end else if (b[7:4] == 4'b1110) begin
            seq_b  = 2'd2;
            pend_b = 2'd2;
            part_b = CP_W'(b[3:0]);
          end else if (b[7:3] == 5'b11110) begin
            seq_b  = 2'd3;
            pend_b = 2'd3;
            part_b = CP_W'(b[2:0]);
          end else begin
            mal_b = 1'b1;
          end
        end else if (!cont_ok) begin
          mal_b = 1'b1;
        end else begin
          part_b = cp_cat;
          pend_b = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            // last continuation: overlong, surrogate and range checks
            mal_b  = range_bad;
            seq_b  = 2'd0;
            part_b = '0;
          end
        end
      end
    end
  end

  // a sequence still open at the end is truncated
  assign mal_end = mal_b || (pend_b != 2'd0);
  assign cnt_ext = (CNT_W + TOTAL_W)'(cnt_b);

  always_comb begin
    if ((cnt_b == CNT_CAP) || (cnt_ext > (CNT_W + TOTAL_W)'(limit_i))) begin
      res_o.verdict = VERDICT_TOO_LONG;
    end else if (ctl_b) begin
      res_o.verdict = VERDICT_CONTROL;
    end else if (mal_end) begin
      res_o.verdict = VERDICT_BAD_UTF8;
    end else begin
      res_o.verdict = VERDICT_VALID;
    end
    if (cnt_ext > (CNT_W + TOTAL_W)'({TOTAL_W{1'b1}})) begin
      res_o.byte_total = '1;
    end else begin
      res_o.byte_total = cnt_ext[TOTAL_W-1:0];
    end
  end

  always_comb begin
    pend_d = pend_q;
    seq_d  = seq_q;
    part_d = part_q;
    cnt_d  = cnt_q;
    ctl_d  = ctl_q;
    mal_d  = mal_q;
    if (fire_i) begin
      if (item_i.string_end) begin
        pend_d = '0;
        seq_d  = '0;
        part_d = '0;
        cnt_d  = '0;
        ctl_d  = 1'b0;
        mal_d  = 1'b0;
      end else begin
        pend_d = pend_b;
        seq_d  = seq_b;
        part_d = part_b;
        cnt_d  = cnt_b;
        ctl_d  = ctl_b;
        mal_d  = mal_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      seq_q  <= '0;
      part_q <= '0;
      cnt_q  <= '0;
      ctl_q  <= 1'b0;
      mal_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      seq_q  <= seq_d;
      part_q <= part_d;
      cnt_q  <= cnt_d;
      ctl_q  <= ctl_d;
      mal_q  <= mal_d;
    end
  end

  `UTV_ASSERT_IMP(a_pend_in_seq, pend_q != 2'd0, (seq_q != 2'd0) && (pend_q <= seq_q))
  `UTV_ASSERT_NXT(a_clear_after_end, fire_i && item_i.string_end, (cnt_q == '0) && (pend_q == 2'd0) && !mal_q && !ctl_q)

endmodule
